/* rtl/pidl_pkg.sv */
// ----------------------------------------------------------------------------
// Positional list package
// Shared types, command codes, status codes and cell operations.
// ----------------------------------------------------------------------------
`default_nettype none

package pidl_pkg;

   localparam int DATA_W = 32;
   localparam int POS_W  = 8;
   localparam int LEN_W  = 9;

   typedef logic signed [DATA_W-1:0] data_type;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_DELETE = 2'd1;
   localparam logic [1:0] CMD_READ   = 2'd2;
   localparam logic [1:0] CMD_CLEAR  = 2'd3;

   localparam logic [1:0] STS_OK    = 2'd0;
   localparam logic [1:0] STS_FULL  = 2'd1;
   localparam logic [1:0] STS_EMPTY = 2'd2;
   localparam logic [1:0] STS_PAST  = 2'd3;

   localparam logic [2:0] OP_HOLD   = 3'd0;
   localparam logic [2:0] OP_INSERT = 3'd1;
   localparam logic [2:0] OP_DELETE = 3'd2;
   localparam logic [2:0] OP_LOAD   = 3'd3;
   localparam logic [2:0] OP_SHIFT  = 3'd4;

   typedef struct packed {
      logic [2:0]       op;
      logic [POS_W-1:0] pos;
   } cell_ctrl_type;

endpackage

`default_nettype wire

/* rtl/pidl_cell.sv */
// ----------------------------------------------------------------------------
// Positional list cell
// Holds one list entry and one stage of the read-out chain.
// ----------------------------------------------------------------------------
`default_nettype none

module pidl_cell import pidl_pkg::*; #(
   parameter int INDEX = 0
) (
   input  wire logic          clock,
   input  wire cell_ctrl_type ctrl,
   input  wire data_type      write_value,
   input  wire data_type      entry_left,
   input  wire data_type      entry_right,
   input  wire data_type      read_right,
   output data_type           entry,
   output data_type           read_out
);

   localparam logic [POS_W-1:0] MY_POS = POS_W'(INDEX);

   data_type entry_ff;
   data_type entry_in;
   data_type read_ff;
   data_type read_in;

   always_comb begin
      entry_in = entry_ff;
      read_in  = read_ff;
      case (ctrl.op)
         OP_INSERT: begin
            if (MY_POS == ctrl.pos) begin
               entry_in = write_value;
            end else if (MY_POS > ctrl.pos) begin
               entry_in = entry_left;
            end
         end
         OP_DELETE: begin
            if (MY_POS >= ctrl.pos) begin
               entry_in = entry_right;
            end
         end
         OP_LOAD:  read_in = entry_ff;
         OP_SHIFT: read_in = read_right;
         default:  ;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      read_ff  <= read_in;
   end

   assign entry    = entry_ff;
   assign read_out = read_ff;

endmodule

`default_nettype wire

/* rtl/positional_insert_delete_list.sv */
// ----------------------------------------------------------------------------
// Positional insert/delete list
// Ordered list of signed 32-bit values kept in a row of shifting cells.
//
//   Channel  Direction  Fields
//   req      in         command, index, write_value
//   rsp      out        status, read_value, length
//
// Insert, delete, clear and refused reads are answered in the cycle after the request is taken.
// A successful read loads every cell's read stage, shifts the chain toward
// cell zero until the indexed entry reaches it, then registers the response.
// Reset empties the list; cell contents are not cleared.
// A request is taken while no read is in progress and the response register is empty or being drained.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_insert_delete_list import pidl_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_command,
   input  wire logic [POS_W-1:0]   req_index,
   input  wire data_type           req_write_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [1:0]              rsp_status,
   output data_type                rsp_read_value,
   output logic [LEN_W-1:0]        rsp_length
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SH_W  = $clog2(DEPTH);
   localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(DEPTH);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   logic                 state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [SH_W-1:0]      shift_ff, shift_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           status_ff, status_in;
   data_type             rdval_ff, rdval_in;
   logic [LEN_W-1:0]     len_ff, len_in;

   cell_ctrl_type        ctrl;
   data_type             entry_q [DEPTH];
   data_type             read_q [DEPTH];

   logic                 accept;
   logic [LEN_W-1:0]     cnt_len;
   logic [LEN_W-1:0]     idx_len;
   logic [POS_W-1:0]     del_pos;

   assign cnt_len   = LEN_W'(count_ff);
   assign idx_len   = {1'b0, req_index};
   assign del_pos   = (req_index <= POS_W'(1)) ? '0 : req_index - POS_W'(1);
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      shift_in     = shift_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      rdval_in     = rdval_ff;
      len_in       = len_ff;
      ctrl.op      = OP_HOLD;
      ctrl.pos     = req_index;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               status_in    = STS_OK;
               rdval_in     = '0;
               rsp_valid_in = 1'b1;
               unique case (req_command)
                  CMD_INSERT: begin
                     if (cnt_len >= DEPTH_LEN) begin
                        status_in = STS_FULL;
                     end else begin
                        ctrl.op  = OP_INSERT;
                        ctrl.pos = (idx_len < cnt_len) ? req_index : POS_W'(count_ff);
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_DELETE: begin
                     if (count_ff == '0) begin
                        status_in = STS_EMPTY;
                     end else if ({1'b0, del_pos} >= cnt_len) begin
                        status_in = STS_PAST;
                     end else begin
                        ctrl.op  = OP_DELETE;
                        ctrl.pos = del_pos;
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  CMD_READ: begin
                     if (count_ff == '0) begin
                        status_in = STS_EMPTY;
                     end else if (idx_len >= cnt_len) begin
                        status_in = STS_PAST;
                     end else begin
                        ctrl.op      = OP_LOAD;
                        shift_in     = req_index[SH_W-1:0];
                        state_in     = ST_READ;
                        rsp_valid_in = 1'b0;
                     end
                  end
                  CMD_CLEAR: begin
                     count_in = '0;
                  end
               endcase
               len_in = LEN_W'(count_in);
            end
         end
         ST_READ: begin
            if (shift_ff == '0) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               status_in    = STS_OK;
               rdval_in     = read_q[0];
               len_in       = cnt_len;
            end else begin
               ctrl.op  = OP_SHIFT;
               shift_in = shift_ff - SH_W'(1);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      shift_ff  <= shift_in;
      status_ff <= status_in;
      rdval_ff  <= rdval_in;
      len_ff    <= len_in;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      data_type left_w;
      data_type right_w;
      data_type read_right_w;

      if (i == 0) begin : g_first
         assign left_w = req_write_value;
      end else begin : g_mid_left
         assign left_w = entry_q[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_w      = '0;
         assign read_right_w = '0;
      end else begin : g_mid_right
         assign right_w      = entry_q[i+1];
         assign read_right_w = read_q[i+1];
      end

      pidl_cell #(.INDEX(i)) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .write_value (req_write_value),
         .entry_left  (left_w),
         .entry_right (right_w),
         .read_right  (read_right_w),
         .entry       (entry_q[i]),
         .read_out    (read_q[i])
      );
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_read_value = rdval_ff;
   assign rsp_length     = len_ff;

endmodule

`default_nettype wire

/* rtl/pidl_checker.sv */
// ----------------------------------------------------------------------------
// Positional list checker
// Port-level assertions on the response channel of the list.
// ----------------------------------------------------------------------------
`default_nettype none

module pidl_checker import pidl_pkg::*; #(
   parameter int DEPTH = 16
) (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [1:0]         rsp_status,
   input wire data_type           rsp_read_value,
   input wire logic [LEN_W-1:0]   rsp_length
);

   localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(DEPTH);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_read_value) && $stable(rsp_length))
      else $error("Response changed while stalled.");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_length <= DEPTH_LEN)
      else $error("Response length exceeds the list depth.");

   a_full_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STS_FULL |-> rsp_length == DEPTH_LEN)
      else $error("Full status with a list that is not full.");

   a_empty_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STS_EMPTY |-> rsp_length == '0)
      else $error("Empty status with a list that is not empty.");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STS_OK |-> rsp_read_value == '0)
      else $error("Refused request returned a nonzero read value.");

endmodule

bind positional_insert_delete_list pidl_checker #(.DEPTH(DEPTH)) u_pidl_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_status     (rsp_status),
   .rsp_read_value (rsp_read_value),
   .rsp_length     (rsp_length)
);

`default_nettype wire

/* test/list_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list checker
// Watches the request and response channels of the positional list. It keeps
// its own copy of the list, predicts one response per accepted request, and
// compares every accepted response field by field with the oldest prediction.
// ----------------------------------------------------------------------------

module list_checker import pidl_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [1:0]        req_command,
   input  logic [POS_W-1:0]  req_index,
   input  data_type          req_write_value,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [1:0]        rsp_status,
   input  data_type          rsp_read_value,
   input  logic [LEN_W-1:0]  rsp_length,
   output int                mismatch_count,
   output int                responses_due,
   output int                responses_checked,
   output int                full_refusals,
   output int                read_hits
);

   typedef struct packed {
      logic [1:0]       status;
      data_type         read_value;
      logic [LEN_W-1:0] length;
   } list_result_type;

   data_type        cells [DEPTH];
   int              list_len;
   list_result_type due_results [$];

   function automatic list_result_type list_apply(input logic [1:0] cmd,
                                                  input logic [POS_W-1:0] idx,
                                                  input data_type val);
      list_result_type res;
      int pos;
      res.status = STS_OK;
      res.read_value = '0;
      case (cmd)
         CMD_INSERT: begin
            if (list_len >= DEPTH) begin
               res.status = STS_FULL;
            end else begin
               pos = (int'(idx) < list_len) ? int'(idx) : list_len;
               for (int i = list_len; i > pos; i--) cells[i] = cells[i-1];
               cells[pos] = val;
               list_len++;
            end
         end
         CMD_DELETE: begin
            pos = (idx <= 1) ? 0 : int'(idx) - 1;
            if (list_len == 0) begin
               res.status = STS_EMPTY;
            end else if (pos >= list_len) begin
               res.status = STS_PAST;
            end else begin
               for (int i = pos; i + 1 < list_len; i++) cells[i] = cells[i+1];
               list_len--;
            end
         end
         CMD_READ: begin
            if (list_len == 0) begin
               res.status = STS_EMPTY;
            end else if (int'(idx) >= list_len) begin
               res.status = STS_PAST;
            end else begin
               res.read_value = cells[idx];
            end
         end
         CMD_CLEAR: begin
            list_len = 0;
         end
      endcase
      res.length = LEN_W'(list_len);
      return res;
   endfunction

   task automatic report(input string what);
      $display("%0t ns mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      list_result_type want;
      if (reset) begin
         list_len = 0;
         due_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               report("response arrived with no request outstanding");
            end else begin
               want = due_results.pop_front();
               responses_checked++;
               if (rsp_status !== want.status)
                  report($sformatf("response %0d status %0d, expected %0d",
                                   responses_checked, rsp_status, want.status));
               if (rsp_read_value !== want.read_value)
                  report($sformatf("response %0d read_value %0d, expected %0d",
                                   responses_checked, rsp_read_value, want.read_value));
               if (rsp_length !== want.length)
                  report($sformatf("response %0d length %0d, expected %0d",
                                   responses_checked, rsp_length, want.length));
            end
         end
         if (req_valid && req_ready) begin
            want = list_apply(req_command, req_index, req_write_value);
            if (want.status == STS_FULL) full_refusals++;
            if (req_command == CMD_READ && want.status == STS_OK) read_hits++;
            due_results.push_back(want);
         end
         responses_due = due_results.size();
      end
   end

endmodule

/* test/tb_positional_insert_delete_list.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list testbench
// Drives insert, delete, read and clear requests into the list, first a
// directed sequence over the edge cases and then random fill, drain and mixed
// runs, with random idle bursts on both channels and one long response stall.
// ----------------------------------------------------------------------------

module tb_positional_insert_delete_list import pidl_pkg::*;;

   localparam int LIST_DEPTH   = 16;
   localparam int ITEM_TARGET  = 900;
   localparam int TAIL_START   = 780;
   localparam int HOLD_AT      = 250;
   localparam int LONG_HOLD    = 120;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 300000;

   localparam data_type VAL_MAX = 32'sh7FFF_FFFF;
   localparam data_type VAL_MIN = 32'sh8000_0000;

   logic             clock;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [1:0]       req_command = CMD_CLEAR;
   logic [POS_W-1:0] req_index = '0;
   data_type         req_write_value = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [1:0]       rsp_status;
   data_type         rsp_read_value;
   logic [LEN_W-1:0] rsp_length;

   int mismatch_count;
   int responses_due;
   int responses_checked;
   int full_refusals;
   int read_hits;

   int sent_count;
   int command_counts [4];
   bit tail_phase;
   bit long_hold_done;

   positional_insert_delete_list #(
      .DEPTH(LIST_DEPTH)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_command(req_command),
      .req_index(req_index),
      .req_write_value(req_write_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_read_value(rsp_read_value),
      .rsp_length(rsp_length)
   );

   list_checker #(
      .DEPTH(LIST_DEPTH)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_command(req_command),
      .req_index(req_index),
      .req_write_value(req_write_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_read_value(rsp_read_value),
      .rsp_length(rsp_length),
      .mismatch_count(mismatch_count),
      .responses_due(responses_due),
      .responses_checked(responses_checked),
      .full_refusals(full_refusals),
      .read_hits(read_hits)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Timed out after %0d cycles with %0d responses due.",
               CYCLE_LIMIT, responses_due);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      int n;
      while (reset) @(posedge clock);
      forever begin
         if (!long_hold_done && sent_count >= HOLD_AT) begin
            long_hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!tail_phase && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 13);
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end else begin
            n = $urandom_range(1, 24);
            rsp_ready <= 1'b1;
            repeat (n) @(posedge clock);
         end
      end
   end

   function automatic logic [POS_W-1:0] pick_index();
      if ($urandom_range(0, 4) == 0) return POS_W'($urandom_range(0, 255));
      return POS_W'($urandom_range(0, LIST_DEPTH + 2));
   endfunction

   function automatic data_type pick_value();
      case ($urandom_range(0, 9))
         0: return VAL_MAX;
         1: return VAL_MIN;
         2: return '0;
         3: return -1;
         default: return data_type'($urandom);
      endcase
   endfunction

   function automatic logic [1:0] pick_command();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35) return CMD_INSERT;
      if (r < 60) return CMD_DELETE;
      if (r < 96) return CMD_READ;
      return CMD_CLEAR;
   endfunction

   task automatic issue(input logic [1:0] cmd, input logic [POS_W-1:0] idx,
                        input data_type val);
      int gap;
      if (!tail_phase && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 13);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_index <= idx;
      req_write_value <= val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      command_counts[cmd]++;
      sent_count++;
      if (sent_count >= TAIL_START) tail_phase = 1'b1;
   endtask

   initial begin
      int run;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      issue(CMD_CLEAR, 8'd0, '0);
      issue(CMD_READ, 8'd0, '0);
      issue(CMD_DELETE, 8'd0, '0);
      issue(CMD_INSERT, 8'd0, VAL_MAX);
      issue(CMD_INSERT, 8'd255, VAL_MIN);
      issue(CMD_INSERT, 8'd1, '0);
      issue(CMD_INSERT, 8'd0, -1);
      issue(CMD_READ, 8'd0, '0);
      issue(CMD_READ, 8'd3, '0);
      issue(CMD_READ, 8'd4, '0);
      issue(CMD_READ, 8'd255, '0);
      issue(CMD_DELETE, 8'd0, '0);
      issue(CMD_DELETE, 8'd1, '0);
      issue(CMD_DELETE, 8'd3, '0);
      issue(CMD_DELETE, 8'd2, '0);
      issue(CMD_DELETE, 8'd255, '0);
      issue(CMD_INSERT, 8'd128, 32'sh5555_5555);
      issue(CMD_READ, 8'd1, '0);
      issue(CMD_CLEAR, 8'd170, 32'shAAAA_AAAA);
      issue(CMD_READ, 8'd0, '0);

      while (sent_count < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               run = $urandom_range(10, 20);
               repeat (run) issue(CMD_INSERT, pick_index(), pick_value());
            end
            3, 4: begin
               run = $urandom_range(5, 20);
               repeat (run) issue(CMD_DELETE, pick_index(), pick_value());
            end
            5, 6, 7: begin
               repeat (10) issue(pick_command(), pick_index(), pick_value());
            end
            8: begin
               for (int i = 0; i < LIST_DEPTH + 2; i++)
                  issue(CMD_READ, POS_W'(i), pick_value());
            end
            default: begin
               issue(CMD_CLEAR, pick_index(), pick_value());
               run = $urandom_range(1, 3);
               repeat (run) issue(pick_command(), pick_index(), pick_value());
            end
         endcase
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (responses_due != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests: %0d inserts, %0d deletes, %0d reads, %0d clears.",
               sent_count, command_counts[CMD_INSERT], command_counts[CMD_DELETE],
               command_counts[CMD_READ], command_counts[CMD_CLEAR]);
      $display("Checked %0d responses, %0d full-list refusals, %0d reads that hit.",
               responses_checked, full_refusals, read_hits);
      if (mismatch_count == 0 && responses_due == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* positional_insert_delete_list.f */
rtl/pidl_pkg.sv
rtl/pidl_cell.sv
rtl/positional_insert_delete_list.sv
rtl/pidl_checker.sv
test/list_checker.sv
test/tb_positional_insert_delete_list.sv
